>>> src/isort_pkg.sv
// isort_pkg: shared types for the insertion sorter.
// Used by isort_cell and insertion_sorter_top; no dependencies.
`default_nettype none
package isort_pkg;

	typedef logic signed [31:0] word_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic insert;  // place the broadcast value this cycle
		logic shift;   // move contents one cell toward cell 0
	} cell_ctrl_t;

endpackage
`default_nettype wire

>>> src/insertion_sorter_top.sv
// insertion_sorter_top: stable ascending sorter built as a row of cells.
// Depends on isort_pkg and isort_cell.
`default_nettype none
// Usage: send signed values one item per cycle; each is inserted into a row of
// MAX_COUNT cells in the cycle it is accepted, so insertion runs at one item per
// clock while in_stall is low. Equal values keep arrival order. The item with
// is_last set is inserted too and then the row drains from cell 0: a set leaves as
// one result item per value held (at most MAX_COUNT), one per cycle when the
// output is not stalled, the largest marked with is_last_res. While the set drains,
// in_stall is high. Values arriving on a full row are dropped and every result of
// that set carries dropped = 1. The fill count and drop flag clear when the final
// result is taken; there is no clearing pass after reset.
module insertion_sorter_top #(
	parameter int MAX_COUNT = 64
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  isort_pkg::word_t        value,
	input  wire                     is_last,
	output logic                    out_valid,
	input  wire                     out_stall,
	output isort_pkg::word_t        value_res,
	output logic                    is_last_res,
	output logic                    dropped
);

	localparam int CW = $clog2(MAX_COUNT + 1);

	logic [CW-1:0]          count_q;
	logic                   draining_q;
	logic                   overflow_q;
	logic                   in_acc, out_acc, full;
	isort_pkg::cell_ctrl_t  ctrl;

	isort_pkg::word_t       vals [MAX_COUNT];
	logic [MAX_COUNT-1:0]   gts;
	logic [MAX_COUNT-1:0]   occs;

	// input is held off for the whole drain of a set
	assign in_stall  = draining_q;
	assign out_valid = draining_q;
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign full      = (count_q == CW'(MAX_COUNT));

	assign ctrl.insert = in_acc && !full;
	assign ctrl.shift  = out_acc;

	// results come straight from cell 0, which holds while stalled
	assign value_res   = vals[0];
	assign is_last_res = (count_q == CW'(1));
	assign dropped     = overflow_q;

	genvar i;
	generate
		for (i = 0; i < MAX_COUNT; i++) begin : g_cell
			isort_pkg::word_t lv, rv;
			logic lg, lo;

			// occupancy is the thermometer form of the fill count
			assign occs[i] = (count_q > CW'(i));

			if (i == 0) begin : g_first
				assign lv = value;
				assign lg = 1'b0;
				assign lo = 1'b1;
			end else begin : g_mid
				assign lv = vals[i-1];
				assign lg = gts[i-1];
				assign lo = occs[i-1];
			end

			if (i == MAX_COUNT - 1) begin : g_end
				assign rv = vals[i];
			end else begin : g_inner
				assign rv = vals[i+1];
			end

			isort_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.ins_value (value),
				.occ       (occs[i]),
				.left_occ  (lo),
				.left_gt   (lg),
				.left_val  (lv),
				.right_val (rv),
				.val       (vals[i]),
				.gt        (gts[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			draining_q <= 1'b0;
			overflow_q <= 1'b0;
		end else if (draining_q) begin
			if (out_acc) begin
				count_q <= count_q - CW'(1);
				if (count_q == CW'(1)) begin
					draining_q <= 1'b0;
					overflow_q <= 1'b0;
				end
			end
		end else if (in_acc) begin
			if (full) begin
				overflow_q <= 1'b1;
			end else begin
				count_q <= count_q + CW'(1);
			end
			if (is_last) begin
				draining_q <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_COUNT))
		else $error("fill count above capacity");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> count_q != '0)
		else $error("draining an empty row");

	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && is_last |=> draining_q)
		else $error("last item did not start drain");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && is_last_res |=> !draining_q && count_q == '0 && !overflow_q)
		else $error("set end did not clear state");
`endif

endmodule
`default_nettype wire

>>> src/isort_cell.sv
// isort_cell: one compare-and-shift cell of the sorting row.
// Depends on isort_pkg (word_t, cell_ctrl_t).
`default_nettype none
module isort_cell (
	input  wire                     clk,
	input  isort_pkg::cell_ctrl_t   ctrl,
	input  isort_pkg::word_t        ins_value,
	input  wire                     occ,
	input  wire                     left_occ,
	input  wire                     left_gt,
	input  isort_pkg::word_t        left_val,
	input  isort_pkg::word_t        right_val,
	output isort_pkg::word_t        val,
	output logic                    gt
);

	isort_pkg::word_t val_q;
	logic take;

	// strict compare keeps equal values ahead of the new one
	assign gt   = occ && (val_q > ins_value);
	assign take = gt || (!occ && left_occ);
	assign val  = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (left_gt) begin
				val_q <= left_val;
			end else if (take) begin
				val_q <= ins_value;
			end
		end else if (ctrl.shift) begin
			val_q <= right_val;
		end
	end

endmodule
`default_nettype wire
